// ===== rtl/core/c2dbm_pkg.sv =====
// shared types and constants for the c2 debug bus master
package c2dbm_pkg;

  // command codes on the command channel
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_AR_READ  = 3'd1;
  localparam logic [2:0] CMD_AR_WRITE = 3'd2;
  localparam logic [2:0] CMD_DR_READ  = 3'd3;
  localparam logic [2:0] CMD_DR_WRITE = 3'd4;
  localparam logic [2:0] CMD_RESET    = 3'd5;

  // two-bit instruction codes sent on the bus
  localparam logic [1:0] INS_DATA_READ  = 2'b00;
  localparam logic [1:0] INS_DATA_WRITE = 2'b01;
  localparam logic [1:0] INS_ADDR_READ  = 2'b10;
  localparam logic [1:0] INS_ADDR_WRITE = 2'b11;

  // reset value of the target reset length register
  localparam logic [15:0] RESET_LOW_TICKS_DEF = 16'd20;

  // bits per address or data byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // frame sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_INS0  = 4'd2,
    PH_INS1  = 4'd3,
    PH_LEN0  = 4'd4,
    PH_LEN1  = 4'd5,
    PH_BITS  = 4'd6,
    PH_WAIT1 = 4'd7,
    PH_WAITP = 4'd8,
    PH_STOP  = 4'd9,
    PH_RESET = 4'd10
  } phase_t;

  // one bus tick as presented on the command channel
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       data_line_in;
  } item_t;

  // pin levels and status for one tick
  typedef struct packed {
    logic       clock_line;
    logic       data_line_out;
    logic       data_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } result_t;

  // instruction code for a bus command
  function automatic logic [1:0] ins_code(input logic [2:0] c);
    logic [1:0] r;
    r = INS_DATA_READ;
    if (c == CMD_AR_READ) r = INS_ADDR_READ;
    else if (c == CMD_AR_WRITE) r = INS_ADDR_WRITE;
    else if (c == CMD_DR_WRITE) r = INS_DATA_WRITE;
    return r;
  endfunction

endpackage

// ===== rtl/core/c2dbm_if.sv =====
// channel interfaces of the c2 debug bus master

// command channel: one bus tick per transaction
interface c2dbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] write_byte;
  logic       data_line_in;
  modport source (output valid, cmd, write_byte, data_line_in, input ready);
  modport sink (input valid, cmd, write_byte, data_line_in, output ready);
endinterface

// result channel: pin levels and status for one tick
interface c2dbm_res_if;
  logic       valid;
  logic       ready;
  logic       clock_line;
  logic       data_line_out;
  logic       data_drive_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  modport source (output valid, clock_line, data_line_out, data_drive_enable, busy_res,
                  done_res, read_byte, input ready);
  modport sink (input valid, clock_line, data_line_out, data_drive_enable, busy_res,
                done_res, read_byte, output ready);
endinterface

// configuration channel: target reset length
interface c2dbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/c2dbm_frame.sv =====
// frame sequencer: bus state and per-tick pin levels
module c2dbm_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [15:0]       reset_low_ticks,
  input  c2dbm_pkg::item_t  item,
  output c2dbm_pkg::result_t res
);
  import c2dbm_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  active_command, active_command_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] reset_tick_counter, reset_tick_counter_next;
  logic        strobe_half, strobe_half_next;

  logic        rd;
  logic        is_data;
  logic [1:0]  ins;
  logic [15:0] limit;
  logic [3:0]  bc_inc;

  // next state and pin levels for this tick
  always_comb begin
    phase_next              = phase;
    active_command_next     = active_command;
    bit_counter_next        = bit_counter;
    shift_byte_next         = shift_byte;
    reset_tick_counter_next = reset_tick_counter;
    strobe_half_next        = strobe_half;
    res                     = '0;
    res.clock_line          = 1'b1;
    rd                      = 1'b0;
    is_data                 = 1'b0;
    ins                     = INS_DATA_READ;
    limit                   = 16'd1;
    bc_inc                  = '0;

    // idle tick takes a command
    if (phase == PH_IDLE || phase > PH_RESET) begin
      phase_next = PH_IDLE;
      if (item.cmd >= CMD_AR_READ && item.cmd <= CMD_DR_WRITE) begin
        active_command_next = item.cmd;
        phase_next          = PH_START;
        bit_counter_next    = '0;
        shift_byte_next     = (item.cmd == CMD_AR_WRITE || item.cmd == CMD_DR_WRITE) ?
                              item.write_byte : 8'h00;
        strobe_half_next    = 1'b0;
      end else if (item.cmd == CMD_RESET) begin
        active_command_next     = item.cmd;
        phase_next              = PH_RESET;
        reset_tick_counter_next = '0;
      end
    end

    rd      = (active_command_next == CMD_AR_READ) || (active_command_next == CMD_DR_READ);
    is_data = (active_command_next == CMD_DR_READ) || (active_command_next == CMD_DR_WRITE);
    ins     = ins_code(active_command_next);

    if (phase_next == PH_RESET) begin
      // target reset: clock held low
      limit                   = (reset_low_ticks == 16'd0) ? 16'd1 : reset_low_ticks;
      res.busy_res            = 1'b1;
      res.clock_line          = 1'b0;
      reset_tick_counter_next = reset_tick_counter_next + 16'd1;
      if (reset_tick_counter_next >= limit) begin
        res.done_res            = 1'b1;
        phase_next              = PH_IDLE;
        reset_tick_counter_next = '0;
      end
    end else if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;
      // low half of a strobe: wait release and read sampling
      if (!strobe_half_next) begin
        if (phase_next == PH_WAITP && item.data_line_in) begin
          if (active_command_next == CMD_DR_READ) begin
            phase_next       = PH_BITS;
            bit_counter_next = '0;
          end else begin
            phase_next = PH_STOP;
          end
        end
        if (rd && ((phase_next == PH_BITS && bit_counter_next != 4'd0) ||
                   phase_next == PH_STOP)) begin
          shift_byte_next = {item.data_line_in, shift_byte_next[7:1]};
        end
        res.clock_line = 1'b0;
      end

      // data pin drive
      unique case (phase_next)
        PH_INS0: begin
          res.data_drive_enable = 1'b1;
          res.data_line_out     = ins[0];
        end
        PH_INS1: begin
          res.data_drive_enable = 1'b1;
          res.data_line_out     = ins[1];
        end
        PH_LEN0, PH_LEN1: begin
          res.data_drive_enable = 1'b1;
        end
        PH_BITS: begin
          if (!rd) begin
            res.data_drive_enable = 1'b1;
            res.data_line_out     = shift_byte_next[0];
          end
        end
        default: begin
        end
      endcase

      // high half ends the strobe and advances the phase (PH_WAITP is left from the low half)
      if (!strobe_half_next) begin
        strobe_half_next = 1'b1;
      end else begin
        strobe_half_next = 1'b0;
        unique case (phase_next)
          PH_START: phase_next = PH_INS0;
          PH_INS0:  phase_next = PH_INS1;
          PH_INS1: begin
            if (is_data) begin
              phase_next = PH_LEN0;
            end else begin
              phase_next       = PH_BITS;
              bit_counter_next = '0;
            end
          end
          PH_LEN0: phase_next = PH_LEN1;
          PH_LEN1: begin
            if (active_command_next == CMD_DR_READ) begin
              phase_next = PH_WAIT1;
            end else begin
              phase_next       = PH_BITS;
              bit_counter_next = '0;
            end
          end
          PH_BITS: begin
            if (!rd) shift_byte_next = {1'b0, shift_byte_next[7:1]};
            bc_inc           = bit_counter_next + 4'd1;
            bit_counter_next = bc_inc;
            if (bc_inc >= BYTE_BITS) begin
              bit_counter_next = '0;
              phase_next       = (active_command_next == CMD_DR_WRITE) ? PH_WAIT1 : PH_STOP;
            end
          end
          PH_WAIT1: phase_next = PH_WAITP;
          PH_WAITP: begin
          end
          default: begin
            res.done_res  = 1'b1;
            res.read_byte = rd ? shift_byte_next : 8'h00;
            phase_next    = PH_IDLE;
          end
        endcase
      end
    end
  end

  // state registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      active_command     <= CMD_NONE;
      bit_counter        <= '0;
      shift_byte         <= '0;
      reset_tick_counter <= '0;
      strobe_half        <= 1'b0;
    end else if (en) begin
      phase              <= phase_next;
      active_command     <= active_command_next;
      bit_counter        <= bit_counter_next;
      shift_byte         <= shift_byte_next;
      reset_tick_counter <= reset_tick_counter_next;
      strobe_half        <= strobe_half_next;
    end
  end

endmodule

// ===== rtl/core/c2_debug_bus_master.sv =====
// top level of the c2 debug bus master
//
//   channel   dir   transaction
//   cmd_ch    in    one bus tick: cmd, write_byte, data_line_in
//   res_ch    out   pin levels and status for that tick
//   cfg_ch    in    target reset length in ticks
//
// one result per command transaction; a new transaction can be taken every
// cycle while res_ch does not stall. the path is an input register, then the
// frame sequencer feeding a result register. stalls on res_ch hold both stages;
// the input register takes a transaction only when it is empty or moving on.
// synchronous reset returns the bus to idle and the reset length to 20 ticks.
module c2_debug_bus_master (
  input logic         clk,
  input logic         rst,
  c2dbm_cmd_if.sink   cmd_ch,
  c2dbm_res_if.source res_ch,
  c2dbm_cfg_if.sink   cfg_ch
);
  import c2dbm_pkg::*;

  logic [15:0] reset_low_ticks;
  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  result_t     step_res;
  logic        adv;

  // stage handshakes
  assign adv          = in_valid && (!out_valid || res_ch.ready);
  assign cmd_ch.ready = !in_valid || adv;
  assign cfg_ch.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks <= RESET_LOW_TICKS_DEF;
    end else if (cfg_ch.valid) begin
      reset_low_ticks <= cfg_ch.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      in_valid <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      in_item <= '{cmd: cmd_ch.cmd, write_byte: cmd_ch.write_byte,
                   data_line_in: cmd_ch.data_line_in};
    end
  end

  // frame sequencer
  c2dbm_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .en              (adv),
    .reset_low_ticks (reset_low_ticks),
    .item            (in_item),
    .res             (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  // result channel
  assign res_ch.valid             = out_valid;
  assign res_ch.clock_line        = out_res.clock_line;
  assign res_ch.data_line_out     = out_res.data_line_out;
  assign res_ch.data_drive_enable = out_res.data_drive_enable;
  assign res_ch.busy_res          = out_res.busy_res;
  assign res_ch.done_res          = out_res.done_res;
  assign res_ch.read_byte         = out_res.read_byte;

endmodule
